// ===== rtl/voxel_trilinear_sampler_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the voxel trilinear sampler
// Shared property forms: same-cycle and next-cycle implication under reset.
// ----------------------------------------------------------------------------
`ifndef VOXEL_TRILINEAR_SAMPLER_UNIT_ASSERT_SVH
`define VOXEL_TRILINEAR_SAMPLER_UNIT_ASSERT_SVH

// Check that expr holds in the same cycle as cond
`define VTS_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Check that expr holds in the cycle after cond
`define VTS_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== rtl/vts_pkg.sv =====
// ----------------------------------------------------------------------------
// vts_pkg
// Widths, fixed-point constants and item codes of the voxel sampler.
// ----------------------------------------------------------------------------
package vts_pkg;

  // Volume store
  localparam int ADDR_W = 18;
  localparam int VOX_W  = 8;

  // Query coordinates: signed Q2.16
  localparam int COORD_W = 18;
  localparam int FRAC_W  = 16;

  // Config and result widths
  localparam int ISO_W    = 16;
  localparam int SAMPLE_W = 17;

  // Q0.16 one, used for the complementary weight
  localparam logic [FRAC_W:0] FRAC_ONE = (FRAC_W + 1)'(1 << FRAC_W);

  // Weighted sum widths: three Q0.16 factors times a byte
  localparam int WXY_W  = 2 * (FRAC_W + 1);
  localparam int WXYZ_W = 3 * FRAC_W + 1;
  localparam int ACC_W  = 3 * FRAC_W + VOX_W;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Default volume dimensions
  localparam int DEFAULT_SIZE_X = 64;
  localparam int DEFAULT_SIZE_Y = 64;
  localparam int DEFAULT_SIZE_Z = 64;

endpackage

// ===== rtl/vts_ram.sv =====
// ----------------------------------------------------------------------------
// vts_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module vts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the addressed entry when enabled, and read it on every clock
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/voxel_trilinear_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// voxel_trilinear_sampler_unit
// Byte voxel volume with trilinear point sampling against an iso level.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. kind selects a
//   voxel write (voxel_address, voxel_value) or a point query (point_x/y/z,
//   signed Q2.16, volume spanning -1 to 1 on each axis).
//   A write completes in its accept cycle; writes may follow back to back
//   and busy stays low. A query raises busy until its result is out.
//   Each query gives one result: sample_valid pulses for one cycle with
//   sample_value (signed Q9.8, density minus iso_level) and out_of_volume.
//   A query whose cell lies in the volume maps the point and forms the base
//   address in the MAP, CELL, ADDR_Y and ADDR_X states, reads the eight
//   corners through the single volume memory port, one per cycle, and lets
//   the multiply pipeline drain before it shows its result. busy falls with
//   the result strobe, so the next item can be taken in the result cycle.
//   An out-of-volume query reports from the CELL state without corner reads.
//   iso_level must be written through cfg_write_en / cfg_write_data only while idle; the block does not enforce it.
//   Reset clears the control state and iso_level; the volume contents are
//   undefined until written. The receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
`include "voxel_trilinear_sampler_unit_assert.svh"

module voxel_trilinear_sampler_unit #(
  parameter int SIZE_X = vts_pkg::DEFAULT_SIZE_X,
  parameter int SIZE_Y = vts_pkg::DEFAULT_SIZE_Y,
  parameter int SIZE_Z = vts_pkg::DEFAULT_SIZE_Z
) (
  input  logic                                clk,
  input  logic                                rst,
  // Item channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                kind,
  input  logic [vts_pkg::ADDR_W-1:0]          voxel_address,
  input  logic [vts_pkg::VOX_W-1:0]           voxel_value,
  input  logic signed [vts_pkg::COORD_W-1:0]  point_x,
  input  logic signed [vts_pkg::COORD_W-1:0]  point_y,
  input  logic signed [vts_pkg::COORD_W-1:0]  point_z,
  // Config register
  input  logic                                cfg_write_en,
  input  logic [vts_pkg::ISO_W-1:0]           cfg_write_data,
  // Result channel
  output logic                                sample_valid,
  output logic signed [vts_pkg::SAMPLE_W-1:0] sample_value,
  output logic                                out_of_volume
);

  import vts_pkg::*;

  // Cell index width covers 1.5x the largest dimension
  localparam int SIZE_MAX = (SIZE_X > SIZE_Y) ? ((SIZE_X > SIZE_Z) ? SIZE_X : SIZE_Z)
                                              : ((SIZE_Y > SIZE_Z) ? SIZE_Y : SIZE_Z);
  localparam int CW = $clog2(SIZE_MAX) + 1;
  localparam int MW = COORD_W + CW + 2;
  localparam int DEPTH = 1 << ADDR_W;

  localparam logic [CW-1:0] X_LAST = CW'(SIZE_X - 1);
  localparam logic [CW-1:0] Y_LAST = CW'(SIZE_Y - 1);
  localparam logic [CW-1:0] Z_LAST = CW'(SIZE_Z - 1);
  localparam logic [CW-1:0] X_DIM  = CW'(SIZE_X);
  localparam logic [CW-1:0] Y_DIM  = CW'(SIZE_Y);

  // Address steps between corners, modulo the store size
  localparam logic [ADDR_W-1:0] OFF_Y = ADDR_W'(SIZE_X);
  localparam logic [ADDR_W-1:0] OFF_Z = ADDR_W'(SIZE_X * SIZE_Y);

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (3 * FRAC_W - VOX_W - 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MAP    = 3'd1;
  localparam logic [2:0] ST_CELL   = 3'd2;
  localparam logic [2:0] ST_ADDR_Y = 3'd3;
  localparam logic [2:0] ST_ADDR_X = 3'd4;
  localparam logic [2:0] ST_READ   = 3'd5;
  localparam logic [2:0] ST_DRAIN  = 3'd6;

  logic [2:0] state;
  logic [2:0] corner;
  logic       stage1_valid;
  logic       stage2_valid;
  logic       stage3_valid;
  logic [ISO_W-1:0] iso_level;

  // Datapath registers
  logic signed [COORD_W-1:0] px, py, pz;
  logic signed [MW-1:0]      mx, my, mz;
  logic [CW-1:0]             cx, cy, cz;
  logic [FRAC_W-1:0]         fx, fy, fz;
  logic [ADDR_W-1:0]         yz_addr;
  logic [ADDR_W-1:0]         base_addr;
  logic [WXY_W-1:0]          wxy;
  logic [FRAC_W:0]           wz_s1;
  logic [WXYZ_W-1:0]         wxyz;
  logic [VOX_W-1:0]          vox_s2;
  logic [ACC_W-1:0]          prod;
  logic [ACC_W-1:0]          acc;

  // Combinational terms
  logic signed [COORD_W:0]   px_ext, py_ext, pz_ext;
  logic signed [MW-1:0]      mx_next, my_next, mz_next;
  logic [CW-1:0]             cx_next, cy_next, cz_next;
  logic                      fail_next;
  logic [2*CW:0]             yz_full;
  logic [ADDR_W+CW:0]        base_full;
  logic [ADDR_W-1:0]         corner_addr;
  logic [FRAC_W:0]           wx_sel, wy_sel, wz_sel;
  logic [ACC_W-1:0]          acc_round;
  logic [FRAC_W-1:0]         density;
  logic                      pipe_empty;
  logic                      take_item;
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_addr;
  logic [VOX_W-1:0]          ram_rdata;

  assign busy      = (state != ST_IDLE);
  assign take_item = start && !busy;
  assign ram_we    = take_item && (kind == KIND_WRITE);

  // Map each axis to (p + 1) * (size - 1) in units of 2^-16
  assign px_ext  = (COORD_W + 1)'(px) + (COORD_W + 1)'(FRAC_ONE);
  assign py_ext  = (COORD_W + 1)'(py) + (COORD_W + 1)'(FRAC_ONE);
  assign pz_ext  = (COORD_W + 1)'(pz) + (COORD_W + 1)'(FRAC_ONE);
  assign mx_next = px_ext * $signed({1'b0, X_LAST});
  assign my_next = py_ext * $signed({1'b0, Y_LAST});
  assign mz_next = pz_ext * $signed({1'b0, Z_LAST});

  // Split into cell index and flag cells outside the volume
  assign cx_next   = mx[FRAC_W+1 +: CW];
  assign cy_next   = my[FRAC_W+1 +: CW];
  assign cz_next   = mz[FRAC_W+1 +: CW];
  assign fail_next = mx[MW-1] || my[MW-1] || mz[MW-1] ||
                     (cx_next >= X_LAST) || (cy_next >= Y_LAST) || (cz_next >= Z_LAST);

  // Base address in two multiply steps
  assign yz_full   = (2 * CW + 1)'(cz * Y_DIM) + (2 * CW + 1)'(cy);
  assign base_full = (ADDR_W + CW + 1)'(yz_addr * X_DIM) + (ADDR_W + CW + 1)'(cx);

  // Corner address and weights for the corner being issued
  assign corner_addr = base_addr + (corner[0] ? ADDR_W'(1) : '0) +
                       (corner[1] ? OFF_Y : '0) + (corner[2] ? OFF_Z : '0);
  assign wx_sel = corner[0] ? {1'b0, fx} : FRAC_ONE - {1'b0, fx};
  assign wy_sel = corner[1] ? {1'b0, fy} : FRAC_ONE - {1'b0, fy};
  assign wz_sel = corner[2] ? {1'b0, fz} : FRAC_ONE - {1'b0, fz};

  assign ram_addr = busy ? corner_addr : voxel_address;

  // Round the Q48 sum half up to Q8.8
  assign acc_round  = acc + ROUND_HALF;
  assign density    = acc_round[ACC_W-1 -: FRAC_W];
  assign pipe_empty = !stage1_valid && !stage2_valid && !stage3_valid;

  vts_ram #(
    .WIDTH (VOX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (voxel_value),
    .rdata (ram_rdata)
  );

  // Hold the iso level
  always_ff @(posedge clk) begin
    if (rst) begin
      iso_level <= '0;
    end else if (cfg_write_en) begin
      iso_level <= cfg_write_data;
    end
  end

  // Advance the query sequencer and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      corner       <= '0;
      stage1_valid <= 1'b0;
      stage2_valid <= 1'b0;
      stage3_valid <= 1'b0;
      sample_valid <= 1'b0;
    end else begin
      sample_valid <= 1'b0;
      stage1_valid <= 1'b0;
      stage2_valid <= stage1_valid;
      stage3_valid <= stage2_valid;
      case (state)
        ST_IDLE: begin
          if (take_item && (kind == KIND_QUERY)) begin
            state <= ST_MAP;
          end
        end
        ST_MAP: begin
          state <= ST_CELL;
        end
        ST_CELL: begin
          if (fail_next) begin
            sample_valid <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            state <= ST_ADDR_Y;
          end
        end
        ST_ADDR_Y: begin
          state <= ST_ADDR_X;
        end
        ST_ADDR_X: begin
          corner <= '0;
          state  <= ST_READ;
        end
        ST_READ: begin
          stage1_valid <= 1'b1;
          corner       <= corner + 3'd1;
          if (corner == 3'd7) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (pipe_empty) begin
            sample_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Capture the point and carry the mapping stages
  always_ff @(posedge clk) begin
    if (take_item) begin
      px <= point_x;
      py <= point_y;
      pz <= point_z;
    end
    if (state == ST_MAP) begin
      mx <= mx_next;
      my <= my_next;
      mz <= mz_next;
    end
    if (state == ST_CELL) begin
      cx <= cx_next;
      cy <= cy_next;
      cz <= cz_next;
      fx <= mx[FRAC_W:1];
      fy <= my[FRAC_W:1];
      fz <= mz[FRAC_W:1];
    end
    if (state == ST_ADDR_Y) begin
      yz_addr <= ADDR_W'(yz_full);
    end
    if (state == ST_ADDR_X) begin
      base_addr <= ADDR_W'(base_full);
    end
  end

  // Weight, multiply and accumulate one corner per cycle
  always_ff @(posedge clk) begin
    wxy    <= wx_sel * wy_sel;
    wz_s1  <= wz_sel;
    wxyz   <= WXYZ_W'(wxy * wz_s1);
    vox_s2 <= ram_rdata;
    prod   <= ACC_W'(wxyz * vox_s2);
    if (state == ST_ADDR_X) begin
      acc <= '0;
    end else if (stage3_valid) begin
      acc <= acc + prod;
    end
  end

  // Drive the result fields
  always_ff @(posedge clk) begin
    if (state == ST_CELL && fail_next) begin
      sample_value  <= '0;
      out_of_volume <= 1'b1;
    end else if (state == ST_DRAIN && pipe_empty) begin
      sample_value  <= $signed({1'b0, density}) - $signed({1'b0, iso_level});
      out_of_volume <= 1'b0;
    end
  end

  `VTS_ASSERT_IMPLY(a_fail_zero, clk, rst, sample_valid && out_of_volume, sample_value == '0, "failed query gave a nonzero sample")
  `VTS_ASSERT_IMPLY(a_write_idle, clk, rst, ram_we, state == ST_IDLE, "voxel write while a query runs")
  `VTS_ASSERT_NEXT(a_query_busy, clk, rst, take_item && (kind == KIND_QUERY), busy, "accepted query did not raise busy")
  `VTS_ASSERT_NEXT(a_single_pulse, clk, rst, sample_valid, !sample_valid, "result strobe longer than one cycle")
  `VTS_ASSERT_IMPLY(a_acc_window, clk, rst, stage3_valid, state == ST_READ || state == ST_DRAIN, "corner product outside the read window")

endmodule
